@@ src/srbp_pkg.sv @@
package srbp_pkg;

    localparam int LANES       = 8;
    localparam int LANE_W      = $clog2(LANES);
    localparam int FILL_W      = $clog2(LANES + 1);
    localparam int ROW_W       = 24;
    localparam int COL_W       = 24;
    localparam int VAL_W       = 32;
    localparam int LANE_PORT_W = 4;
    localparam int RUN_W       = 5;

    // Write requests from the collector to the two packet RAMs.
    typedef struct packed {
        logic              entry_we;
        logic [LANE_W-1:0] entry_addr;
        logic              run_we;
        logic [LANE_W-1:0] run_addr;
        logic [RUN_W-1:0]  run_data;
    } ram_wr_t;

    // Packet status held by the collector and read by the emit sequencer.
    typedef struct packed {
        logic              close;
        logic [FILL_W-1:0] fill;
        logic [LANE_W-1:0] run_count;
        logic              new_row;
    } pkt_status_t;

endpackage

@@ src/srbp_ram.sv @@
module srbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/srbp_collect.sv @@
module srbp_collect
    import srbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [ROW_W-1:0] row,
    input  logic             final_entry,
    input  logic             emit_done,
    input  logic             cfg_write,
    input  logic [ROW_W-1:0] cfg_data,
    output ram_wr_t          ram_wr,
    output pkt_status_t      status
);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LANE_W-1:0] run_reg, run_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  prev_row_reg, prev_row_next;
    logic              new_row_reg, new_row_next;
    logic              first;
    logic              close;

    assign first = (fill_reg == '0);
    assign close = accept && ((fill_reg == FILL_W'(LANES - 1)) || final_entry);

    always_comb
    begin
        fill_next     = fill_reg;
        run_next      = run_reg;
        new_row_next  = new_row_reg;
        prev_row_next = prev_row_reg;
        if (cfg_write)
        begin
            prev_row_next = cfg_data;
        end
        if (emit_done)
        begin
            fill_next = '0;
            run_next  = '0;
        end
        if (accept)
        begin
            fill_next = fill_reg + FILL_W'(1);
            if (first)
            begin
                new_row_next = (row != prev_row_reg);
                run_next     = '0;
            end
            else if (row != cur_row_reg && run_reg != LANE_W'(LANES - 1))
            begin
                run_next = run_reg + LANE_W'(1);
            end
            if (close)
            begin
                prev_row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            run_reg      <= '0;
            cur_row_reg  <= '0;
            prev_row_reg <= '0;
            new_row_reg  <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            run_reg      <= run_next;
            new_row_reg  <= new_row_next;
            prev_row_reg <= prev_row_next;
            if (accept)
            begin
                cur_row_reg <= row;
            end
        end
    end

    // The run end of the current run is rewritten with every entry it gains.
    assign ram_wr.entry_we   = accept;
    assign ram_wr.entry_addr = fill_reg[LANE_W-1:0];
    assign ram_wr.run_we     = accept;
    assign ram_wr.run_addr   = run_next;
    assign ram_wr.run_data   = RUN_W'(fill_reg) + RUN_W'(1);

    assign status.close     = close;
    assign status.fill      = fill_reg;
    assign status.run_count = run_reg;
    assign status.new_row   = new_row_reg;

endmodule

@@ src/sparse_row_block_packer.sv @@
// Sparse row block packer.
// Row-sorted sparse entries (row, column, value, final_entry) enter one item
// per cycle on the input channel (in_valid / in_stall). They collect into a
// packet of LANES entries; the packet closes when it is full or when an item
// carries final_entry, in which case the remaining lanes are zero padding.
// A closed packet leaves on the output channel as LANES items, one per lane
// in lane order, each with its column, value, run end offset, the packet's
// new-row flag and packet_end on the last lane.
// Entries and run ends sit in two small RAMs with a registered read port.
// After the closing entry, emission starts with the RAM read of lane zero;
// then, lane by lane, the output register loads and the lane is offered
// until taken, and while it is taken the read of the following lane is
// issued. The input channel stalls for the whole emission.
// Output stall holds the current lane item unchanged; the block moves on to
// the next lane only when the current lane is taken.
// Reset clears the packet, the run tracking and the previous row (to zero).
// A write on cfg_write loads cfg_data as the previous packet row; the
// user must make it while the block is idle; the block does not enforce it.
module sparse_row_block_packer
    import srbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [ROW_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ROW_W-1:0]       row,
    input  logic [COL_W-1:0]       column,
    input  logic [VAL_W-1:0]       value,
    input  logic                   final_entry,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LANE_PORT_W-1:0] lane,
    output logic [COL_W-1:0]       lane_column,
    output logic [VAL_W-1:0]       lane_value,
    output logic [RUN_W-1:0]       run_end,
    output logic                   new_row,
    output logic                   packet_end
);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t              state_reg;
    logic [LANE_W-1:0]   lane_reg;
    logic                accept;
    logic                emit_done;
    logic                out_take;
    ram_wr_t             ram_wr;
    pkt_status_t         status;
    logic [LANE_W-1:0]   rd_addr;
    logic [COL_W+VAL_W-1:0] entry_rdata;
    logic [RUN_W-1:0]    run_rdata;
    logic                lane_filled;
    logic                lane_in_run;
    logic                last_lane;

    assign in_stall  = (state_reg != ST_COLLECT);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;
    assign last_lane = (lane_reg == LANE_W'(LANES - 1));
    assign emit_done = (state_reg == ST_SEND) && out_take && last_lane;

    srbp_collect u_collect (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .row         (row),
        .final_entry (final_entry),
        .emit_done   (emit_done),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .ram_wr      (ram_wr),
        .status      (status)
    );

    // While a lane is taken, the read of the following lane is issued.
    assign rd_addr = (state_reg == ST_SEND) ? lane_reg + LANE_W'(1) : lane_reg;

    srbp_ram #(
        .WIDTH (COL_W + VAL_W),
        .DEPTH (LANES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr.entry_we),
        .wr_addr (ram_wr.entry_addr),
        .wr_data ({column, value}),
        .rd_addr (rd_addr),
        .rd_data (entry_rdata)
    );

    srbp_ram #(
        .WIDTH (RUN_W),
        .DEPTH (LANES)
    ) u_run_ram (
        .clk     (clk),
        .wr_en   (ram_wr.run_we),
        .wr_addr (ram_wr.run_addr),
        .wr_data (ram_wr.run_data),
        .rd_addr (rd_addr),
        .rd_data (run_rdata)
    );

    // Lanes beyond the fill count are padding; lanes beyond the last run
    // report the fill count as their run end.
    assign lane_filled = (FILL_W'(lane_reg) < status.fill);
    assign lane_in_run = (lane_reg <= status.run_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            lane_reg    <= '0;
            out_valid   <= 1'b0;
            lane        <= '0;
            lane_column <= '0;
            lane_value  <= '0;
            run_end     <= '0;
            new_row     <= 1'b0;
            packet_end  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_COLLECT:
                begin
                    if (status.close)
                    begin
                        lane_reg  <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    out_valid   <= 1'b1;
                    lane        <= LANE_PORT_W'(lane_reg);
                    lane_column <= lane_filled ? entry_rdata[COL_W+VAL_W-1:VAL_W] : '0;
                    lane_value  <= lane_filled ? entry_rdata[VAL_W-1:0] : '0;
                    run_end     <= lane_in_run ? run_rdata : RUN_W'(status.fill);
                    new_row     <= status.new_row;
                    packet_end  <= last_lane;
                    state_reg   <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (out_take)
                    begin
                        out_valid <= 1'b0;
                        if (last_lane)
                        begin
                            state_reg <= ST_COLLECT;
                        end
                        else
                        begin
                            lane_reg  <= lane_reg + LANE_W'(1);
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

endmodule

@@ src/srbp_check.sv @@
module srbp_check
    import srbp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [LANE_PORT_W-1:0] lane,
    input logic [COL_W-1:0]       lane_column,
    input logic [VAL_W-1:0]       lane_value,
    input logic [RUN_W-1:0]       run_end,
    input logic                   new_row,
    input logic                   packet_end
);

    // No item is taken in while a packet is being sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && !in_stall))
    else $error("input accepted during packet emission");

    // Lanes of a packet follow one another in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !packet_end |=> ##1
            (out_valid && lane == $past(lane, 2) + LANE_PORT_W'(1)))
    else $error("lane sequence broken");

    // Only the last lane ends a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packet_end == (lane == LANE_PORT_W'(LANES - 1))))
    else $error("packet_end on wrong lane");

    // A run end never passes the packet size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_end <= RUN_W'(LANES))
    else $error("run end out of range");

    // A stalled item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lane) && $stable(lane_column)
            && $stable(lane_value) && $stable(run_end) && $stable(new_row))
    else $error("stalled output item changed");

endmodule

bind sparse_row_block_packer srbp_check u_check (.*);

@@ bench/tb_sparse_row_block_packer.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the sparse row block packer.
// Sparse entries go in one item per handshake. A predictor in this module
// keeps its own copy of the packet state and queues the lane items that
// every closing entry must produce. A checker process takes each lane item
// that leaves the block and compares it, field by field, with the oldest
// queued lane item. The run is a sequence of test tasks: a directed part,
// then random partitions under several idling patterns, then a part that
// holds the output off long enough to back the block up into its input.
module tb_sparse_row_block_packer;

    import srbp_pkg::*;

    // This many quiet cycles are enough for the block to settle after the
    // last lane item.
    localparam int SETTLE_CYCLES = 3 * LANES + 8;

    // The longest correct stretch without any handshake is the output
    // hold-off below plus a run of random stall or idle cycles.
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 60;

    // One lane item as the block must emit it.
    typedef struct {
        logic [LANE_PORT_W-1:0] lane;
        logic [COL_W-1:0]       column;
        logic [VAL_W-1:0]       value;
        logic [RUN_W-1:0]       run_end;
        logic                   new_row;
        logic                   packet_end;
    } lane_item_t;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   cfg_write   = 1'b0;
    logic [ROW_W-1:0]       cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [ROW_W-1:0]       row         = '0;
    logic [COL_W-1:0]       column      = '0;
    logic [VAL_W-1:0]       value       = '0;
    logic                   final_entry = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [LANE_PORT_W-1:0] lane;
    logic [COL_W-1:0]       lane_column;
    logic [VAL_W-1:0]       lane_value;
    logic [RUN_W-1:0]       run_end;
    logic                   new_row;
    logic                   packet_end;

    // Idling controls: percent of cycles in which the sender offers nothing
    // and in which the receiver stalls, plus a long output hold-off.
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic holding       = 1'b0;
    event hold_go;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Lane items still owed by the block, oldest first.
    lane_item_t lanes_due[$];

    // Predicted packet state.
    logic [ROW_W-1:0] prev_row  = '0;
    logic [ROW_W-1:0] run_row   = '0;
    logic             pkt_new   = 1'b0;
    int               fill      = 0;
    int               runs      = 0;
    logic [COL_W-1:0] col_buf [LANES];
    logic [VAL_W-1:0] val_buf [LANES];
    logic [RUN_W-1:0] run_buf [LANES];

    sparse_row_block_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row         (row),
        .column      (column),
        .value       (value),
        .final_entry (final_entry),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lane        (lane),
        .lane_column (lane_column),
        .lane_value  (lane_value),
        .run_end     (run_end),
        .new_row     (new_row),
        .packet_end  (packet_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Adds one accepted entry to the predicted packet. When the entry
    // closes the packet, either because the packet is full or because the
    // entry ends the partition, all LANES lane items are queued. A row that
    // differs from the current run's row, also a lower one, opens a new run;
    // the last lane's run absorbs any further row changes. Lanes past the
    // valid count are zero padding whose run end is the valid count.
    function automatic void pack_entry(input logic [ROW_W-1:0] r,
                                       input logic [COL_W-1:0] c,
                                       input logic [VAL_W-1:0] v,
                                       input logic             fin);
        lane_item_t item;
        if (fill == 0)
        begin
            pkt_new = (r != prev_row);
            runs    = 0;
        end
        else if (r != run_row && runs + 1 < LANES)
        begin
            runs++;
        end
        run_row       = r;
        col_buf[fill] = c;
        val_buf[fill] = v;
        fill++;
        run_buf[runs] = RUN_W'(fill);
        if (fill < LANES && !fin)
            return;
        for (int k = 0; k < LANES; k++)
        begin
            item.lane       = LANE_PORT_W'(k);
            item.column     = (k < fill) ? col_buf[k] : '0;
            item.value      = (k < fill) ? val_buf[k] : '0;
            item.run_end    = (k <= runs) ? run_buf[k] : RUN_W'(fill);
            item.new_row    = pkt_new;
            item.packet_end = (k == LANES - 1);
            lanes_due.insert(lanes_due.size(), item);
        end
        prev_row = run_row;
        fill     = 0;
        runs     = 0;
    endfunction

    // Only the first few mismatches are printed; all of them are counted.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offers one entry and returns at the clock edge that accepts it. Before
    // the entry goes out, the sender may idle for a random number of cycles.
    // Valid stays high after acceptance, so the caller either sends the next
    // entry at once or lowers valid through wait_results_out.
    task automatic send_entry(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                              input logic [VAL_W-1:0] v, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        row         <= r;
        column      <= c;
        value       <= v;
        final_entry <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pack_entry(r, c, v, fin);
    endtask

    // Stops offering entries and waits until every owed lane item is out.
    task automatic wait_results_out();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lanes_due.size() != 0)
            @(posedge clk);
    endtask

    // The start row is written only with no packet open and the block quiet.
    task automatic load_start_row(input logic [ROW_W-1:0] start);
        wait_results_out();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= start;
        @(posedge clk);
        cfg_write <= 1'b0;
        prev_row = start;
    endtask

    // Sends a partition of random entries. Most steps keep the row or move
    // it up a little, so packets hold real runs; some jump far, some land
    // anywhere in the row range and some step down. Entries end the
    // partition now and then, and the last one always does, so no packet
    // stays open when the task returns.
    task automatic send_random_entries(input int count, input logic [ROW_W-1:0] row_origin);
        logic [ROW_W-1:0] r;
        int               pick;
        logic             fin;
        r = row_origin;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (i != 0)
            begin
                if (pick < 50)
                    r = r;
                else if (pick < 80)
                    r = r + ROW_W'($urandom_range(3, 1));
                else if (pick < 90)
                    r = r + ROW_W'($urandom_range(4000, 4));
                else if (pick < 96)
                    r = ROW_W'($urandom);
                else
                    r = r - ROW_W'($urandom_range(2, 1));
            end
            fin = (i == count - 1) || ($urandom_range(99) < 8);
            send_entry(r, COL_W'($urandom), $urandom, fin);
        end
    endtask

    // Directed part: extreme columns and values, a single long run, a packet
    // with a lower row and rows at the top of the range, a packet in which
    // every lane opens its own run, a one-entry packet, and padding after a
    // start row at its top value.
    task automatic test_directed();
        logic [ROW_W-1:0] mixed_rows [8] = '{24'h000001, 24'h000002, 24'h000002,
                                            24'h000001, 24'hFFFFFF, 24'hFFFFFF,
                                            24'hFFFFFF, 24'hFFFFFE};
        send_idle_pct = 0;
        stall_pct     = 0;
        load_start_row('0);
        // Same row as the start row: no new row, one run over all lanes.
        for (int i = 0; i < LANES; i++)
            send_entry('0, (i % 2) ? '1 : '0, (i % 2) ? '1 : '0, 1'b0);
        // The last entry both fills the packet and ends the partition.
        for (int i = 0; i < $size(mixed_rows); i++)
            send_entry(mixed_rows[i], COL_W'(24'h800000 >> i), 32'h8000_0001 << i,
                       i == $size(mixed_rows) - 1);
        // Starts on the previous packet's last row, then wraps to zero and
        // changes row on every entry after that.
        send_entry(24'hFFFFFE, 24'h123456, 32'hDEAD_BEEF, 1'b0);
        for (int i = 1; i < LANES; i++)
            send_entry(ROW_W'(i - 1), COL_W'(i), VAL_W'(i * 3), 1'b0);
        // A packet of one valid entry, on the same row as before.
        send_entry(ROW_W'(LANES - 2), 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1);
        load_start_row('1);
        send_entry('0, 24'h000001, 32'h0000_0001, 1'b1);
        send_entry('1, 24'hABCDEF, 32'h5555_AAAA, 1'b1);
    endtask

    task automatic test_steady_stream();
        logic [ROW_W-1:0] start;
        start = ROW_W'($urandom);
        send_idle_pct = 0;
        stall_pct     = 0;
        load_start_row(start);
        send_random_entries(80, start);
    endtask

    // Rows start just below the top of the range, so they wrap around.
    task automatic test_sender_gaps();
        send_idle_pct = 74;
        stall_pct     = 0;
        load_start_row(24'hFFFFF8);
        send_random_entries(70, 24'hFFFFF8);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct     = 74;
        load_start_row(ROW_W'($urandom));
        send_random_entries(70, ROW_W'($urandom));
    endtask

    task automatic test_both_idle();
        send_idle_pct = 17;
        stall_pct     = 17;
        load_start_row('0);
        send_random_entries(70, ROW_W'($urandom_range(3, 0)));
    endtask

    // The receiver holds off while entries keep coming, so the block fills
    // a packet and then stalls its input. Afterwards the sender pauses until
    // every owed lane item is out before it starts again.
    task automatic test_backpressure();
        logic [ROW_W-1:0] start;
        start = ROW_W'($urandom);
        send_idle_pct = 0;
        stall_pct     = 0;
        load_start_row(start);
        -> hold_go;
        send_random_entries(45, start);
        wait_results_out();
        stall_pct = 30;
        send_random_entries(20, ROW_W'($urandom));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        wait_results_out();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random stalls at the rate of the current phase, and a
    // solid stall while the hold-off runs.
    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < stall_pct);

    // The hold-off counts its own cycles once a test asks for it.
    initial
    begin
        forever
        begin
            @(hold_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Every lane item taken from the block must match the oldest owed one.
    always @(posedge clk)
    begin : check_lanes
        lane_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lanes_due.size() == 0)
            begin
                flag_mismatch("lane item with none owed, lane", 32'(lane), 'x);
            end
            else
            begin
                want = lanes_due.pop_front();
                if (lane !== want.lane)
                    flag_mismatch("lane", 32'(lane), 32'(want.lane));
                if (lane_column !== want.column)
                    flag_mismatch("lane_column", 32'(lane_column), 32'(want.column));
                if (lane_value !== want.value)
                    flag_mismatch("lane_value", lane_value, want.value);
                if (run_end !== want.run_end)
                    flag_mismatch("run_end", 32'(run_end), 32'(want.run_end));
                if (new_row !== want.new_row)
                    flag_mismatch("new_row", 32'(new_row), 32'(want.new_row));
                if (packet_end !== want.packet_end)
                    flag_mismatch("packet_end", 32'(packet_end), 32'(want.packet_end));
            end
        end
    end

    // Watchdog: too many cycles in a row without a handshake on either
    // channel means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TIMEOUT at %0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
